[rtl/core/bctp_pkg.sv]
// Package for the capability TLV parser: codes, result kinds, phases and
// the word types shared by the front end, the op queue and the back end.
// No dependencies.
package bctp_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] CodeAsn4 = 8'd65;
  localparam logic [7:0] CodeMp   = 8'd1;
  localparam logic [7:0] KnownLen = 8'd4;

  typedef enum logic [2:0] {
    KIND_ASN4 = 3'd0,
    KIND_MP   = 3'd1,
    KIND_HDR  = 3'd2,
    KIND_VAL  = 3'd3,
    KIND_BAD  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DROP  = 2'd3
  } phase_e;

  typedef enum logic {
    OP_SHIFT = 1'b0,
    OP_EMIT  = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  cap_code;
    logic [31:0] asn;
    logic [15:0] afi;
    logic [7:0]  safi;
    logic [7:0]  value_byte;
    logic [7:0]  value_length;
    logic        end_of_capability;
  } out_word_t;

  typedef struct packed {
    op_e        op;
    kind_e      kind;
    logic [7:0] cap_code;
    logic [7:0] value_length;
    logic       eoc;
    logic [7:0] data_byte;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_known(input logic [7:0] code);
    return (code == CodeAsn4) || (code == CodeMp);
  endfunction

endpackage

[rtl/core/bctp_front.sv]
// Front end: tracks the TLV phase per byte and turns result and value bytes into ops.
// Depends on bctp_pkg.
module bctp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  bctp_pkg::in_word_t in_word_i,
  output logic              push_o,
  output bctp_pkg::op_t     op_o
);

  bctp_pkg::phase_e phase_q, phase_d;
  logic [7:0] code_q, code_d;
  logic [7:0] len_q, len_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] seen_inc;
  logic [7:0] b;
  logic       last;

  assign b        = in_word_i.data_byte;
  assign last     = in_word_i.end_of_buffer;
  assign seen_inc = seen_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bctp_pkg::PH_CODE;
      code_q  <= '0;
      len_q   <= '0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    len_d   = len_q;
    seen_d  = seen_q;
    if (accept_i) begin
      unique case (phase_q)
        bctp_pkg::PH_CODE: begin
          code_d  = b;
          len_d   = '0;
          seen_d  = '0;
          phase_d = last ? bctp_pkg::PH_CODE : bctp_pkg::PH_LEN;
        end
        bctp_pkg::PH_LEN: begin
          len_d  = b;
          seen_d = '0;
          if (bctp_pkg::is_known(code_q)) begin
            if (b != bctp_pkg::KnownLen || last) begin
              phase_d = last ? bctp_pkg::PH_CODE : bctp_pkg::PH_DROP;
            end else begin
              phase_d = bctp_pkg::PH_VALUE;
            end
          end else if (b == 8'd0 || last) begin
            phase_d = bctp_pkg::PH_CODE;
          end else begin
            phase_d = bctp_pkg::PH_VALUE;
          end
        end
        bctp_pkg::PH_VALUE: begin
          seen_d = seen_inc;
          if (bctp_pkg::is_known(code_q)) begin
            if (seen_inc >= bctp_pkg::KnownLen || last) phase_d = bctp_pkg::PH_CODE;
          end else if (seen_inc >= len_q || last) begin
            phase_d = bctp_pkg::PH_CODE;
          end
        end
        bctp_pkg::PH_DROP: begin
          if (last) phase_d = bctp_pkg::PH_CODE;
        end
        default: phase_d = bctp_pkg::PH_CODE;
      endcase
    end
  end

  always_comb begin
    push_o          = 1'b0;
    op_o.op         = bctp_pkg::OP_EMIT;
    op_o.kind       = bctp_pkg::KIND_BAD;
    op_o.cap_code   = code_q;
    op_o.value_length = len_q;
    op_o.eoc        = 1'b0;
    op_o.data_byte  = b;
    if (accept_i) begin
      unique case (phase_q)
        bctp_pkg::PH_CODE: begin
          op_o.cap_code     = b;
          op_o.value_length = '0;
          push_o            = last;
        end
        bctp_pkg::PH_LEN: begin
          op_o.value_length = b;
          if (bctp_pkg::is_known(code_q)) begin
            push_o = (b != bctp_pkg::KnownLen) || last;
          end else begin
            push_o = 1'b1;
            if (b == 8'd0) begin
              op_o.kind = bctp_pkg::KIND_HDR;
              op_o.eoc  = 1'b1;
            end else if (!last) begin
              op_o.kind = bctp_pkg::KIND_HDR;
            end
          end
        end
        bctp_pkg::PH_VALUE: begin
          push_o = 1'b1;
          if (bctp_pkg::is_known(code_q)) begin
            if (seen_inc >= bctp_pkg::KnownLen) begin
              op_o.kind = (code_q == bctp_pkg::CodeAsn4) ? bctp_pkg::KIND_ASN4
                                                         : bctp_pkg::KIND_MP;
              op_o.eoc  = 1'b1;
            end else if (!last) begin
              op_o.op = bctp_pkg::OP_SHIFT;
            end
          end else if (seen_inc >= len_q) begin
            op_o.kind = bctp_pkg::KIND_VAL;
            op_o.eoc  = 1'b1;
          end else if (!last) begin
            op_o.kind = bctp_pkg::KIND_VAL;
          end
        end
        bctp_pkg::PH_DROP: push_o = 1'b0;
        default: push_o = 1'b0;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bctp_pkg::PH_VALUE && bctp_pkg::is_known(code_q))
      |-> (seen_q < bctp_pkg::KnownLen && len_q == bctp_pkg::KnownLen))
    else $error("known capability value count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bctp_pkg::PH_VALUE && !bctp_pkg::is_known(code_q))
      |-> (len_q != 8'd0 && seen_q < len_q))
    else $error("unknown capability value count out of range");

endmodule

[rtl/core/bctp_queue.sv]
// Short op queue between the front end and the back end.
// Depends on bctp_pkg.
module bctp_queue #(
  parameter int unsigned Depth = bctp_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bctp_pkg::op_t        op_i,
  input  logic                 pop_i,
  output bctp_pkg::op_t        op_o,
  output bctp_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bctp_pkg::op_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign op_o           = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    if (pop_i)  rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= op_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("op queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("op queue underflow");

endmodule

[rtl/core/bctp_back.sv]
// Back end: gathers value bytes of known capabilities and drives the
// registered result word. Depends on bctp_pkg.
module bctp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bctp_pkg::op_t        op_i,
  input  bctp_pkg::q_status_t  status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bctp_pkg::out_word_t  out_data_o
);

  logic [31:0]          shift_q, shift_d;
  logic [31:0]          full_val;
  logic                 valid_q, valid_d;
  bctp_pkg::out_word_t  res_q, res_d;
  logic                 slot_free;

  assign slot_free   = !valid_q || !out_stall_i;
  assign pop_o       = !status_i.empty && (op_i.op == bctp_pkg::OP_SHIFT || slot_free);
  assign full_val    = {shift_q[23:0], op_i.data_byte};
  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    shift_d = shift_q;
    valid_d = valid_q && out_stall_i;
    res_d   = res_q;
    if (pop_o) begin
      shift_d = full_val;
      if (op_i.op == bctp_pkg::OP_EMIT) begin
        valid_d                 = 1'b1;
        res_d.kind              = op_i.kind;
        res_d.cap_code          = op_i.cap_code;
        res_d.value_length      = op_i.value_length;
        res_d.end_of_capability = op_i.eoc;
        res_d.asn        = (op_i.kind == bctp_pkg::KIND_ASN4) ? full_val : '0;
        res_d.afi        = (op_i.kind == bctp_pkg::KIND_MP) ? full_val[31:16] : '0;
        res_d.safi       = (op_i.kind == bctp_pkg::KIND_MP) ? full_val[7:0] : '0;
        res_d.value_byte = (op_i.kind == bctp_pkg::KIND_VAL) ? op_i.data_byte : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    res_q   <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.kind == bctp_pkg::KIND_BAD) |-> !res_q.end_of_capability)
    else $error("bad-length result marked as end of capability");

endmodule

[rtl/core/bgp_capability_tlv_parser.sv]
// Top level of the capability TLV parser: front end, op queue, back end.
// Depends on bctp_pkg, bctp_front, bctp_queue and bctp_back.
//
// Takes one buffer byte per cycle while in_stall_o is low and returns at
// most one result per byte. A result passes the op queue, written when its
// byte is accepted, then the output register, loaded once the output slot
// is free. Input stalls only when the QueueDepth-entry op queue fills,
// which happens only after the output side has stalled; otherwise the rate
// is one byte every cycle. Value bytes of a known capability pass through
// the queue as shift ops and give no result, bar the fourth or a buffer end.
module bgp_capability_tlv_parser #(
  parameter int unsigned QueueDepth = bctp_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bctp_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bctp_pkg::out_word_t  out_data_o
);

  logic                accept;
  logic                push;
  logic                pop;
  bctp_pkg::op_t       front_op;
  bctp_pkg::op_t       head_op;
  bctp_pkg::q_status_t q_status;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  bctp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_data_i),
    .push_o    (push),
    .op_o      (front_op)
  );

  bctp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (front_op),
    .pop_i    (pop),
    .op_o     (head_op),
    .status_o (q_status)
  );

  bctp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (head_op),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[dv/tb_bgp_capability_tlv_parser.sv]
// Testbench for bgp_capability_tlv_parser: drives capability buffers byte by byte,
// predicts each result word in-line and checks it field by field at the output.
// Depends on bctp_pkg and the parser RTL only.
module tb_bgp_capability_tlv_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import bctp_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  bgp_capability_tlv_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  phase_e      tlv_phase = PH_CODE;
  logic [7:0]  tlv_code = '0;
  logic [7:0]  tlv_len = '0;
  logic [7:0]  tlv_seen = '0;
  logic [31:0] tlv_shift = '0;

  in_word_t    bytes_to_send[$];
  out_word_t   results_due[$];
  logic [7:0]  tlv_bytes[$];
  out_word_t   next_due;

  int unsigned queued_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  logic        steady = 1'b0;
  logic        in_taken = 1'b0;

  task automatic flag_error(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got 0x%0h want 0x%0h (cap_code 0x%0h)",
                           name, got, want, next_due.cap_code));
  endtask

  task automatic predict_tlv_byte(input in_word_t w);
    out_word_t  r;
    logic       emit;
    logic       known;
    logic [7:0] b;
    logic       eob;
    r = '0;
    emit = 1'b0;
    b = w.data_byte;
    eob = w.end_of_buffer;
    known = (tlv_code == CodeAsn4) || (tlv_code == CodeMp);
    case (tlv_phase)
      PH_CODE: begin
        tlv_code = b;
        tlv_len = '0;
        tlv_seen = '0;
        tlv_shift = '0;
        if (eob) begin
          r.kind = KIND_BAD;
          emit = 1'b1;
        end else begin
          tlv_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        tlv_len = b;
        tlv_seen = '0;
        tlv_shift = '0;
        r.value_length = b;
        emit = 1'b1;
        if (known) begin
          if (b != KnownLen || eob) begin
            r.kind = KIND_BAD;
            tlv_phase = eob ? PH_CODE : PH_DROP;
          end else begin
            emit = 1'b0;
            tlv_phase = PH_VALUE;
          end
        end else if (b == 8'd0) begin
          r.kind = KIND_HDR;
          r.end_of_capability = 1'b1;
          tlv_phase = PH_CODE;
        end else if (eob) begin
          r.kind = KIND_BAD;
          tlv_phase = PH_CODE;
        end else begin
          r.kind = KIND_HDR;
          tlv_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        tlv_seen = tlv_seen + 8'd1;
        r.value_length = tlv_len;
        if (known) begin
          tlv_shift = {tlv_shift[23:0], b};
          if (tlv_seen >= KnownLen) begin
            emit = 1'b1;
            r.end_of_capability = 1'b1;
            if (tlv_code == CodeAsn4) begin
              r.kind = KIND_ASN4;
              r.asn = tlv_shift;
            end else begin
              r.kind = KIND_MP;
              r.afi = tlv_shift[31:16];
              r.safi = tlv_shift[7:0];
            end
            tlv_phase = PH_CODE;
          end else if (eob) begin
            emit = 1'b1;
            r.kind = KIND_BAD;
            tlv_phase = PH_CODE;
          end
        end else begin
          emit = 1'b1;
          if (tlv_seen >= tlv_len) begin
            r.kind = KIND_VAL;
            r.value_byte = b;
            r.end_of_capability = 1'b1;
            tlv_phase = PH_CODE;
          end else if (eob) begin
            r.kind = KIND_BAD;
            tlv_phase = PH_CODE;
          end else begin
            r.kind = KIND_VAL;
            r.value_byte = b;
          end
        end
      end
      default: begin
        if (eob) tlv_phase = PH_CODE;
      end
    endcase
    r.cap_code = tlv_code;
    if (emit) results_due.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_bgp_capability_tlv_parser: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) predict_tlv_byte(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("result word with none expected (kind %0d)",
                               out_data_o.kind));
        end else begin
          next_due = results_due.pop_front();
          check_field("kind", out_data_o.kind, next_due.kind);
          check_field("cap_code", out_data_o.cap_code, next_due.cap_code);
          check_field("asn", out_data_o.asn, next_due.asn);
          check_field("afi", out_data_o.afi, next_due.afi);
          check_field("safi", out_data_o.safi, next_due.safi);
          check_field("value_byte", out_data_o.value_byte, next_due.value_byte);
          check_field("value_length", out_data_o.value_length, next_due.value_length);
          check_field("end_of_capability", out_data_o.end_of_capability,
                      next_due.end_of_capability);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          if (!steady && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 3);
            in_valid_i <= 1'b0;
          end else begin
            in_data_i <= bytes_to_send.pop_front();
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_gap != 0) begin
        stall_gap <= stall_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_gap <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_buffer();
    in_word_t w;
    foreach (tlv_bytes[i]) begin
      w.data_byte = tlv_bytes[i];
      w.end_of_buffer = (i == tlv_bytes.size() - 1);
      bytes_to_send.push_back(w);
    end
    queued_count += tlv_bytes.size();
    tlv_bytes.delete();
  endtask

  task automatic add_asn4();
    tlv_bytes.push_back(CodeAsn4);
    tlv_bytes.push_back(KnownLen);
    repeat (4) tlv_bytes.push_back(8'($urandom));
  endtask

  task automatic add_mp();
    tlv_bytes.push_back(CodeMp);
    tlv_bytes.push_back(KnownLen);
    repeat (4) tlv_bytes.push_back(8'($urandom));
  endtask

  task automatic add_unknown();
    logic [7:0]  code;
    logic [7:0]  len;
    int unsigned pick;
    code = 8'($urandom);
    while (code == CodeAsn4 || code == CodeMp) code = 8'($urandom);
    pick = $urandom_range(0, 63);
    if (pick == 0) len = 8'd255;
    else if (pick < 5) len = 8'($urandom_range(6, 60));
    else len = 8'($urandom_range(0, 5));
    tlv_bytes.push_back(code);
    tlv_bytes.push_back(len);
    repeat (len) tlv_bytes.push_back(8'($urandom));
  endtask

  task automatic add_random_tlv();
    case ($urandom_range(0, 2))
      0: add_asn4();
      1: add_mp();
      default: add_unknown();
    endcase
  endtask

  task automatic add_bad_known();
    logic [7:0] len;
    len = 8'($urandom);
    if (len == KnownLen) len = len + 8'd1;
    tlv_bytes.push_back($urandom_range(0, 1) ? CodeAsn4 : CodeMp);
    tlv_bytes.push_back(len);
    repeat ($urandom_range(0, 6)) tlv_bytes.push_back(8'($urandom));
  endtask

  task automatic build_buffer();
    int unsigned mode;
    int unsigned cut;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      repeat ($urandom_range(1, 4)) add_random_tlv();
    end else if (mode < 82) begin
      repeat ($urandom_range(1, 3)) add_random_tlv();
      cut = $urandom_range(1, tlv_bytes.size() - 1);
      while (tlv_bytes.size() > cut) tlv_bytes.delete(tlv_bytes.size() - 1);
    end else if (mode < 92) begin
      if ($urandom_range(0, 1)) add_random_tlv();
      add_bad_known();
    end else begin
      repeat ($urandom_range(1, 8)) tlv_bytes.push_back(8'($urandom));
    end
    send_buffer();
  endtask

  task automatic wait_for_drain();
    while (bytes_to_send.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tlv_bytes = '{CodeAsn4, KnownLen, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    tlv_bytes = '{CodeMp, KnownLen, 8'hAB, 8'hCD, 8'h00, 8'hFF,
                  8'h00, 8'h00, 8'hFF, 8'h02, 8'h00, 8'hFF};
    send_buffer();
    tlv_bytes = '{CodeAsn4};
    send_buffer();
    tlv_bytes = '{CodeMp, 8'hFF, 8'h22};
    send_buffer();
    tlv_bytes = '{CodeAsn4, KnownLen, 8'h12};
    send_buffer();
    tlv_bytes = '{8'h09, 8'h03, 8'h77};
    send_buffer();
    tlv_bytes = '{CodeAsn4, KnownLen};
    send_buffer();
    wait_for_drain();

    while (queued_count < 900) build_buffer();
    wait_for_drain();
    while (queued_count < 1400) build_buffer();
    wait_for_drain();
    steady = 1'b1;
    while (queued_count < 1750) build_buffer();
    wait_for_drain();
    repeat (16) @(negedge clk_i);

    if (error_count == 0) begin
      $display("tb_bgp_capability_tlv_parser: done, clean");
    end else begin
      $display("tb_bgp_capability_tlv_parser: done, errors");
    end
    $finish;
  end

endmodule

[bgp_capability_tlv_parser.f]
rtl/core/bctp_pkg.sv
rtl/core/bctp_front.sv
rtl/core/bctp_queue.sv
rtl/core/bctp_back.sv
rtl/core/bgp_capability_tlv_parser.sv
dv/tb_bgp_capability_tlv_parser.sv
